/* src/expiring_entry_table_macros.svh */
// assertion macros for the expiring entry table
// used by the top level, expects clk_i and rst_ni in scope
`ifndef EXPIRING_ENTRY_TABLE_MACROS_SVH
`define EXPIRING_ENTRY_TABLE_MACROS_SVH

// condition holds at every clock edge out of reset
`define EET_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("expiring_entry_table check failed");

// consequent holds in the cycle after the antecedent
`define EET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("expiring_entry_table check failed");

`endif

/* src/eet_pkg.sv */
// shared types and constants of the expiring entry table
// no dependencies
package eet_pkg;

  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned TagBitsDef    = 32;

  localparam int unsigned OpW    = 2;
  localparam int unsigned PayW   = 32;
  localparam int unsigned LifeW  = 31;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned CntOutW = 7;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 80;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_READ,
    S_READ_WAIT,
    S_TICK_START,
    S_TICK_EVAL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic insert;
    logic tick_init;
    logic read_issue;
    logic read_capture;
    logic keep;
    logic drop;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic expire;
    logic at_tail;
    logic out_free;
  } stat_t;

endpackage

/* src/eet_ram.sv */
// generic single write port ram with registered read
// no dependencies
module eet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/eet_dp.sv */
// datapath of the expiring entry table: item registers, count, scan pointer,
// entry ram and result register; depends on eet_pkg and eet_ram
module eet_dp import eet_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned TAG_BITS    = TagBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  output stat_t               stat_o,
  input  logic [InDataW-1:0]  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW   = $clog2(MAX_ENTRIES);
  localparam int unsigned DW   = TAG_BITS + LifeW;
  localparam int unsigned CMPW = (CW > IdxW) ? CW : IdxW + 1;

  logic [PayW-1:0]  pay_q;
  logic [LifeW-1:0] life_q;
  logic [LifeW-1:0] elap_q;
  logic [IdxW-1:0]  idx_q;

  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    removed_q, removed_d;
  logic             ovf_q, ovf_d;
  logic             rd_valid_q, rd_valid_d;
  logic [PayW-1:0]  rd_tag_q, rd_tag_d;
  logic [LifeW-1:0] rd_life_q, rd_life_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [DW-1:0]    wdata, rdata;
  logic [TAG_BITS-1:0] r_tag;
  logic [LifeW-1:0] r_life;
  logic [CMPW-1:0]  idx_w, count_w;
  logic             rd_ok;
  logic [CW-1:0]    count_m1;

  assign r_tag    = rdata[DW-1:LifeW];
  assign r_life   = rdata[LifeW-1:0];
  assign idx_w    = CMPW'(idx_q);
  assign count_w  = CMPW'(count_q);
  assign rd_ok    = idx_w < count_w;
  assign count_m1 = count_q - CW'(1);

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CW'(MAX_ENTRIES));
  assign stat_o.expire   = (r_life < elap_q);
  assign stat_o.at_tail  = (CW'(ptr_q) == count_m1);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // item registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      pay_q  <= in_data_i[31:0];
      life_q <= in_data_i[62:32];
      elap_q <= in_data_i[93:63];
      idx_q  <= in_data_i[99:94];
    end
  end

  // ram port selection
  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = {r_tag, r_life - elap_q};
    raddr = ptr_q;
    if (ctrl_i.insert && !stat_o.full) begin
      we    = 1'b1;
      waddr = count_q[AW-1:0];
      wdata = {TAG_BITS'(pay_q), life_q};
    end
    if (ctrl_i.keep) begin
      we = 1'b1;
    end
    if (ctrl_i.tick_init) begin
      raddr = '0;
    end else if (ctrl_i.read_issue) begin
      raddr = idx_w[AW-1:0];
    end else if (ctrl_i.keep) begin
      raddr = ptr_q + AW'(1);
    end else if (ctrl_i.drop) begin
      raddr = count_m1[AW-1:0];
    end
  end

  eet_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d    = count_q;
    ptr_d      = ptr_q;
    removed_d  = removed_q;
    ovf_d      = ovf_q;
    rd_valid_d = rd_valid_q;
    rd_tag_d   = rd_tag_q;
    rd_life_d  = rd_life_q;
    if (ctrl_i.load) begin
      removed_d  = '0;
      ovf_d      = 1'b0;
      rd_valid_d = 1'b0;
      rd_tag_d   = '0;
      rd_life_d  = '0;
    end
    if (ctrl_i.insert) begin
      if (stat_o.full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
    if (ctrl_i.tick_init) begin
      ptr_d = '0;
    end
    if (ctrl_i.keep) begin
      ptr_d = ptr_q + AW'(1);
    end
    if (ctrl_i.drop) begin
      count_d   = count_m1;
      removed_d = removed_q + CW'(1);
    end
    if (ctrl_i.read_capture && rd_ok) begin
      rd_valid_d = 1'b1;
      rd_tag_d   = PayW'(r_tag);
      rd_life_d  = r_life;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, rd_life_q, rd_tag_q, rd_valid_q, ovf_q,
                     CntOutW'(removed_q), CntOutW'(count_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      removed_q   <= '0;
      ovf_q       <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      removed_q   <= removed_d;
      ovf_q       <= ovf_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q   <= rd_tag_d;
    rd_life_q  <= rd_life_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/eet_ctrl.sv */
// control state machine of the expiring entry table
// depends on eet_pkg
module eet_ctrl import eet_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [OpW-1:0] in_op_i,
  input  stat_t          stat_i,
  output ctrl_t          ctrl_o,
  output state_e         state_o
);

  state_e state_q, state_d;
  op_e    op;

  assign op = op_e'(in_op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          case (op)
            OP_INSERT: state_d = S_INSERT;
            OP_TICK:   state_d = S_TICK_START;
            OP_READ:   state_d = S_READ;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_INSERT: begin
        ctrl_o.insert = 1'b1;
        state_d       = S_DONE;
      end
      S_READ: begin
        ctrl_o.read_issue = 1'b1;
        state_d           = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        ctrl_o.read_capture = 1'b1;
        state_d             = S_DONE;
      end
      S_TICK_START: begin
        ctrl_o.tick_init = 1'b1;
        state_d          = stat_i.empty ? S_DONE : S_TICK_EVAL;
      end
      S_TICK_EVAL: begin
        if (stat_i.expire) begin
          ctrl_o.drop = 1'b1;
        end else begin
          ctrl_o.keep = 1'b1;
        end
        if (stat_i.at_tail) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.emit = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign state_o = state_q;

endmodule

/* src/expiring_entry_table.sv */
// expiring entry table top level: controller, datapath and entry ram
// insert runs S_INSERT, read S_READ and S_READ_WAIT, tick S_TICK_START and S_TICK_EVAL
// a tick examines the live slots in turn (kept or removed) on the single ram read port
// one transaction in flight; the next is taken the cycle after the result is registered
// reset clears the live count, controller and output valid; entry contents are not cleared
`include "expiring_entry_table_macros.svh"

module expiring_entry_table import eet_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned TAG_BITS    = TagBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // payload[31:0], lifetime[62:32], elapsed[93:63], index[99:94], zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [OpW-1:0]      s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // live_count[6:0], removed[13:7], overflow[14], read_valid[15],
  // read_payload[47:16], read_lifetime[78:48], zero fill
  output logic [OutDataW-1:0] m_axis_tdata
);

  ctrl_t  ctrl;
  stat_t  stat;
  state_e state;

  eet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .state_o    (state)
  );

  eet_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  `EET_ASSERT(a_one_ram_op, $onehot0({ctrl.insert, ctrl.keep, ctrl.drop, ctrl.read_issue, ctrl.tick_init}))
  `EET_ASSERT_NEXT(a_full_insert_holds, ctrl.insert && stat.full, stat.full)
  `EET_ASSERT_NEXT(a_emit_to_idle, ctrl.emit, state == S_IDLE && m_axis_tvalid)
  `EET_ASSERT(a_scan_not_empty, !(state == S_TICK_EVAL && stat.empty))

endmodule
